// File: rtl/vlan_ingress_classify_strip_top_assert.svh
// Assertion macros shared by the checker of the VLAN classifier.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef VLAN_INGRESS_CLASSIFY_STRIP_TOP_ASSERT_SVH
`define VLAN_INGRESS_CLASSIFY_STRIP_TOP_ASSERT_SVH

// Consequent checked in the same cycle, ignored while in reset.
`define VICS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle, ignored while in reset.
`define VICS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle, also while in reset.
`define VICS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vics_pkg.sv
package vics_pkg;

  // Byte and frame layout.
  localparam int BYTE_W     = 8;
  localparam int ADDR_BYTES = 12;             // destination and source MAC
  localparam int ETYPE_SLOT = ADDR_BYTES;     // store slot for frame byte 16
  localparam int HDR_BYTES  = ADDR_BYTES + 1; // slots held per header bank
  localparam int HDR_AW     = 4;              // enough to count to HDR_BYTES

  // Byte positions within a tagged frame.
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_TAG_HI   = 5'd14;
  localparam logic [POS_W-1:0] POS_CLASSIFY = 5'd15;
  localparam logic [POS_W-1:0] POS_ETYPE    = 5'd16;
  localparam logic [POS_W-1:0] POS_EMIT     = 5'd17;
  localparam logic [POS_W-1:0] POS_SAT      = 5'd18;

  // Entry register packing.
  localparam int ENTRY_W      = 18;
  localparam int ENT_ATT      = 17;
  localparam int ENT_UP       = 16;
  localparam int ENT_PORT_LSB = 12;
  localparam int PORT_W       = 4;
  localparam int VID_W        = 12;
  localparam int TAG_HI_W     = VID_W - BYTE_W;

  // Configuration port.
  localparam int CFG_REGS = 4;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // Result fields.
  localparam int IDX_W     = 2;
  localparam int CNT_OUT_W = 32;

  // Command queue between front and back.
  localparam int Q_DEPTH = 16;
  localparam int Q_AW    = 4;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_ENTRIES   = 4;
  localparam int DEF_COUNTER_WIDTH = 32;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [2:0] {
    VERD_UNDEC  = 3'b001,
    VERD_ACCEPT = 3'b010,
    VERD_DROP   = 3'b100
  } verdict_t;

  typedef enum logic {
    CMD_PASS  = 1'b0,
    CMD_BURST = 1'b1
  } cmd_kind_t;

  // One queued command: a single result, or the header burst of a frame.
  typedef struct packed {
    cmd_kind_t             kind;
    logic [BYTE_W-1:0]     data;
    logic [IDX_W-1:0]      idx;
    logic                  done;
    logic                  drop;
    logic [CNT_OUT_W-1:0]  count;
    logic                  bank;
  } cmd_t;

  // Header store read request from the back part.
  typedef struct packed {
    logic              bank;
    logic [HDR_AW-1:0] addr;
  } hdr_rd_t;

  // Header bank handed back once its burst has gone out.
  typedef struct packed {
    logic valid;
    logic bank;
  } hdr_rel_t;

endpackage

// File: rtl/vlan_ingress_classify_strip_top.sv
// Path: a drop word or the first header word is registered in the command queue,
// then in the output register; byte 17 on of an accepted frame follows the stored bytes.
// Throughput: one byte per cycle in, one word per cycle out while the receiver pops; byte 17
// of an accepted frame yields a 14-word header burst, absorbed by the 16-deep command queue.
// Input stalls only when that queue is full or a header byte's bank is still being replayed.
// Reset: synchronous, active low; clears sequencing, entries and packet counters at once.
module vlan_ingress_classify_strip_top
  import vics_pkg::*;
#(
  parameter int NUM_ENTRIES   = DEF_NUM_ENTRIES,
  parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [BYTE_W-1:0]     in_frame_byte,
  input  logic [PORT_W-1:0]     in_arrival_port,
  input  logic                  in_end_of_frame,
  input  logic                  push,
  output logic                  full,
  output logic [BYTE_W-1:0]     out_byte,
  output logic [IDX_W-1:0]      out_vlan_index,
  output logic                  out_frame_done,
  output logic                  out_dropped,
  output logic [CNT_OUT_W-1:0]  out_packet_count,
  output logic                  empty,
  input  logic                  pop,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  entry_t [CFG_REGS-1:0] cfg_r;
  logic                  cfg_wr;
  logic                  q_push, q_full, q_pop, q_empty;
  cmd_t                  q_wr_cmd, q_rd_cmd;
  hdr_rd_t               hdr_rd;
  hdr_rel_t              hdr_rel;
  logic [BYTE_W-1:0]     hdr_rdata;

  // Entry registers, one word apart.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = APB_DW'(cfg_r[paddr[APB_AW-1:2]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      cfg_r[paddr[APB_AW-1:2]] <= pwdata[ENTRY_W-1:0];
    end
  end

  vics_front #(
    .NUM_ENTRIES  (NUM_ENTRIES),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_frame_byte  (in_frame_byte),
    .in_arrival_port(in_arrival_port),
    .in_end_of_frame(in_end_of_frame),
    .push           (push),
    .full           (full),
    .entries        (cfg_r),
    .q_push         (q_push),
    .q_cmd          (q_wr_cmd),
    .q_full         (q_full),
    .rd             (hdr_rd),
    .rd_data        (hdr_rdata),
    .rel            (hdr_rel)
  );

  vics_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_data(q_wr_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rd_cmd),
    .empty  (q_empty)
  );

  vics_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (q_rd_cmd),
    .q_pop           (q_pop),
    .rd              (hdr_rd),
    .rd_data         (hdr_rdata),
    .rel             (hdr_rel),
    .pop             (pop),
    .empty           (empty),
    .out_byte        (out_byte),
    .out_vlan_index  (out_vlan_index),
    .out_frame_done  (out_frame_done),
    .out_dropped     (out_dropped),
    .out_packet_count(out_packet_count)
  );

endmodule

// File: rtl/vics_fifo.sv
module vics_fifo
  import vics_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, wptr_nxt;
  logic [Q_AW-1:0] rptr_r, rptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wptr_nxt  = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_rd ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/vics_front.sv
module vics_front
  import vics_pkg::*;
#(
  parameter int NUM_ENTRIES   = DEF_NUM_ENTRIES,
  parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [BYTE_W-1:0]         in_frame_byte,
  input  logic [PORT_W-1:0]         in_arrival_port,
  input  logic                      in_end_of_frame,
  input  logic                      push,
  output logic                      full,
  input  entry_t [CFG_REGS-1:0]     entries,
  output logic                      q_push,
  output cmd_t                      q_cmd,
  input  logic                      q_full,
  input  hdr_rd_t                   rd,
  output logic [BYTE_W-1:0]         rd_data,
  input  hdr_rel_t                  rel
);

  logic [BYTE_W-1:0]        hdr_r [2][HDR_BYTES];
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [TAG_HI_W-1:0]      tag_hi_r, tag_hi_nxt;
  verdict_t                 verd_r, verd_nxt;
  logic [IDX_W-1:0]         match_r, match_nxt;
  logic                     wbank_r, wbank_nxt;
  logic [1:0]               busy_r, busy_nxt;
  logic [COUNTER_WIDTH-1:0] cnt_r [NUM_ENTRIES];
  logic [COUNTER_WIDTH-1:0] cnt_nxt [NUM_ENTRIES];

  logic                     accept, hdr_wr, bump;
  logic [HDR_AW-1:0]        hdr_waddr;
  logic [VID_W-1:0]         vid;
  logic                     cls_hit, cls_up;
  logic [IDX_W-1:0]         cls_idx;
  logic [COUNTER_WIDTH-1:0] cnt_sel, cnt_inc;
  logic [CNT_OUT_W-1:0]     cnt_sel_out, cnt_inc_out;

  // Header bytes go to the bank being filled; a bank still being read stalls them.
  assign hdr_wr    = (pos_r < POS_W'(ADDR_BYTES)) || (pos_r == POS_ETYPE);
  assign hdr_waddr = (pos_r == POS_ETYPE) ? HDR_AW'(ETYPE_SLOT) : pos_r[HDR_AW-1:0];
  assign full      = q_full || (hdr_wr && busy_r[wbank_r]);
  assign accept    = push && !full;

  assign rd_data = (rd.addr < HDR_AW'(HDR_BYTES)) ? hdr_r[rd.bank][rd.addr] : '0;

  // First attached entry matching port and VLAN id decides the frame.
  assign vid = {tag_hi_r, in_frame_byte};
  always_comb begin
    cls_hit = 1'b0;
    cls_up  = 1'b0;
    cls_idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (entries[i][ENT_ATT] &&
          (entries[i][ENT_PORT_LSB +: PORT_W] == in_arrival_port) &&
          (entries[i][VID_W-1:0] == vid)) begin
        cls_hit = 1'b1;
        cls_up  = entries[i][ENT_UP];
        cls_idx = IDX_W'(i);
      end
    end
  end

  // Counter of the matched entry, before and after this frame's bump.
  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (match_r == IDX_W'(i)) begin
        cnt_sel = cnt_r[i];
      end
    end
  end
  assign cnt_inc = cnt_sel + 1'b1;

  generate
    if (COUNTER_WIDTH >= CNT_OUT_W) begin : g_cnt_trunc
      assign cnt_sel_out = cnt_sel[CNT_OUT_W-1:0];
      assign cnt_inc_out = cnt_inc[CNT_OUT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_sel_out = CNT_OUT_W'(cnt_sel);
      assign cnt_inc_out = CNT_OUT_W'(cnt_inc);
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      cnt_nxt[i] = (bump && (match_r == IDX_W'(i))) ? cnt_inc : cnt_r[i];
    end
  end

  // Frame sequencing and command generation.
  always_comb begin
    pos_nxt    = pos_r;
    tag_hi_nxt = tag_hi_r;
    verd_nxt   = verd_r;
    match_nxt  = match_r;
    wbank_nxt  = wbank_r;
    busy_nxt   = busy_r;
    bump       = 1'b0;
    q_push     = 1'b0;
    q_cmd.kind  = CMD_PASS;
    q_cmd.data  = in_frame_byte;
    q_cmd.idx   = match_r;
    q_cmd.done  = in_end_of_frame;
    q_cmd.drop  = 1'b0;
    q_cmd.count = cnt_sel_out;
    q_cmd.bank  = wbank_r;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept) begin
      if (pos_r == POS_TAG_HI) begin
        tag_hi_nxt = in_frame_byte[TAG_HI_W-1:0];
      end
      if (pos_r == POS_CLASSIFY) begin
        verd_nxt  = (cls_hit && cls_up) ? VERD_ACCEPT : VERD_DROP;
        match_nxt = cls_idx;
      end

      if ((pos_r == POS_EMIT) && (verd_r == VERD_ACCEPT)) begin
        // Header burst: the back part replays the stored bank.
        bump               = 1'b1;
        q_push             = 1'b1;
        q_cmd.kind         = CMD_BURST;
        q_cmd.count        = cnt_inc_out;
        busy_nxt[wbank_r]  = 1'b1;
        wbank_nxt          = ~wbank_r;
      end else if ((pos_r == POS_SAT) && (verd_r == VERD_ACCEPT)) begin
        q_push = 1'b1;
      end else if (in_end_of_frame) begin
        // Dropped or short frame: one bare drop word.
        q_push      = 1'b1;
        q_cmd.data  = '0;
        q_cmd.idx   = '0;
        q_cmd.drop  = 1'b1;
        q_cmd.count = '0;
      end

      if (pos_r < POS_SAT) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (in_end_of_frame) begin
        pos_nxt    = '0;
        verd_nxt   = VERD_UNDEC;
        match_nxt  = '0;
        tag_hi_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      tag_hi_r <= '0;
      verd_r   <= VERD_UNDEC;
      match_r  <= '0;
      wbank_r  <= 1'b0;
      busy_r   <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      pos_r    <= pos_nxt;
      tag_hi_r <= tag_hi_nxt;
      verd_r   <= verd_nxt;
      match_r  <= match_nxt;
      wbank_r  <= wbank_nxt;
      busy_r   <= busy_nxt;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // Header banks hold data only; they have no reset.
  always_ff @(posedge clk) begin
    if (accept && hdr_wr) begin
      hdr_r[wbank_r][hdr_waddr] <= in_frame_byte;
    end
  end

endmodule

// File: rtl/vics_back.sv
module vics_back
  import vics_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output hdr_rd_t               rd,
  input  logic [BYTE_W-1:0]     rd_data,
  output hdr_rel_t              rel,
  input  logic                  pop,
  output logic                  empty,
  output logic [BYTE_W-1:0]     out_byte,
  output logic [IDX_W-1:0]      out_vlan_index,
  output logic                  out_frame_done,
  output logic                  out_dropped,
  output logic [CNT_OUT_W-1:0]  out_packet_count
);

  logic [HDR_AW-1:0]    burst_r, burst_nxt;
  logic                 valid_r, valid_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 done_r, done_nxt;
  logic                 drop_r, drop_nxt;
  logic [CNT_OUT_W-1:0] count_r, count_nxt;
  logic                 load, taken;

  // The output register refills whenever it is free or being taken.
  assign taken = pop && valid_r;
  assign load  = !q_empty && (!valid_r || pop);
  assign rd    = '{bank: q_cmd.bank, addr: burst_r};
  assign empty = !valid_r;

  always_comb begin
    burst_nxt = burst_r;
    valid_nxt = load ? 1'b1 : (taken ? 1'b0 : valid_r);
    byte_nxt  = byte_r;
    idx_nxt   = idx_r;
    done_nxt  = done_r;
    drop_nxt  = drop_r;
    count_nxt = count_r;
    q_pop     = 1'b0;
    rel       = '{valid: 1'b0, bank: q_cmd.bank};

    if (load) begin
      idx_nxt   = q_cmd.idx;
      drop_nxt  = q_cmd.drop;
      count_nxt = q_cmd.count;
      case (q_cmd.kind)
        CMD_BURST: begin
          if (burst_r != HDR_AW'(HDR_BYTES)) begin
            // Replay stored address and ethertype bytes.
            byte_nxt  = rd_data;
            done_nxt  = 1'b0;
            burst_nxt = burst_r + 1'b1;
          end else begin
            // Final word of the burst, then the bank is free again.
            byte_nxt  = q_cmd.data;
            done_nxt  = q_cmd.done;
            burst_nxt = '0;
            q_pop     = 1'b1;
            rel.valid = 1'b1;
          end
        end
        default: begin
          byte_nxt = q_cmd.data;
          done_nxt = q_cmd.done;
          q_pop    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r <= '0;
      valid_r <= 1'b0;
    end else begin
      burst_r <= burst_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    idx_r   <= idx_nxt;
    done_r  <= done_nxt;
    drop_r  <= drop_nxt;
    count_r <= count_nxt;
  end

  assign out_byte         = byte_r;
  assign out_vlan_index   = idx_r;
  assign out_frame_done   = done_r;
  assign out_dropped      = drop_r;
  assign out_packet_count = count_r;

endmodule

// File: rtl/vics_checker.sv
`include "vlan_ingress_classify_strip_top_assert.svh"

module vics_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte,
  input logic [1:0]  out_vlan_index,
  input logic        out_frame_done,
  input logic        out_dropped,
  input logic [31:0] out_packet_count
);

  // Reset leaves no result word waiting.
  `VICS_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, empty, "result present after reset")

  // A word that is not taken stays put.
  `VICS_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_frame_done) && $stable(out_dropped) && $stable(out_packet_count), "waiting word changed")

  // A drop word closes its frame and carries nothing else.
  `VICS_ASSERT_SAME(a_drop_bare, !empty && out_dropped, out_frame_done && (out_byte == 8'd0) && (out_vlan_index == 2'd0) && (out_packet_count == 32'd0), "drop word not bare")

  // An entry written reads back from the next cycle.
  `VICS_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready, (paddr != $past(paddr)) || (prdata[17:0] == $past(pwdata[17:0])), "entry readback mismatch")

endmodule

bind vlan_ingress_classify_strip_top vics_checker u_vics_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .pready          (pready),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .empty           (empty),
  .pop             (pop),
  .out_byte        (out_byte),
  .out_vlan_index  (out_vlan_index),
  .out_frame_done  (out_frame_done),
  .out_dropped     (out_dropped),
  .out_packet_count(out_packet_count)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import vics_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [15:0] TPID = 16'h8100;

  // Configuration register indexes, one per VLAN entry.
  typedef enum int {
    REG_ENTRY_ZERO  = 0,
    REG_ENTRY_ONE   = 1,
    REG_ENTRY_TWO   = 2,
    REG_ENTRY_THREE = 3
  } entry_reg_t;

  // One word on the result side of the block.
  typedef struct packed {
    logic [BYTE_W-1:0]    data;
    logic [IDX_W-1:0]     idx;
    logic                 done;
    logic                 drop;
    logic [CNT_OUT_W-1:0] count;
  } strip_word_t;

  logic                 clk;
  logic                 rst_n;
  logic [BYTE_W-1:0]    in_frame_byte;
  logic [PORT_W-1:0]    in_arrival_port;
  logic                 in_end_of_frame;
  logic                 push;
  logic                 full;
  logic [BYTE_W-1:0]    out_byte;
  logic [IDX_W-1:0]     out_vlan_index;
  logic                 out_frame_done;
  logic                 out_dropped;
  logic [CNT_OUT_W-1:0] out_packet_count;
  logic                 empty;
  logic                 pop;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  vlan_ingress_classify_strip_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_frame_byte    (in_frame_byte),
    .in_arrival_port  (in_arrival_port),
    .in_end_of_frame  (in_end_of_frame),
    .push             (push),
    .full             (full),
    .out_byte         (out_byte),
    .out_vlan_index   (out_vlan_index),
    .out_frame_done   (out_frame_done),
    .out_dropped      (out_dropped),
    .out_packet_count (out_packet_count),
    .empty            (empty),
    .pop              (pop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Predicts the untagged words of each frame and checks them in order.
  class strip_scoreboard;
    entry_t                       entries[CFG_REGS];
    logic [BYTE_W-1:0]            hdr[14];
    logic [POS_W-1:0]             pos;
    logic [BYTE_W-1:0]            tag_hi;
    verdict_t                     verdict;
    logic [IDX_W-1:0]             matched;
    logic [DEF_COUNTER_WIDTH-1:0] counters[CFG_REGS];
    strip_word_t                  expected_words[$];
    int                           failures;

    function new();
      for (int i = 0; i < CFG_REGS; i++) begin
        entries[i]  = '0;
        counters[i] = '0;
      end
      for (int i = 0; i < 14; i++) begin
        hdr[i] = '0;
      end
      pos      = '0;
      tag_hi   = '0;
      verdict  = VERD_UNDEC;
      matched  = '0;
      failures = 0;
    endfunction

    function void set_entry(int idx, logic [APB_DW-1:0] value);
      entries[idx] = value[ENTRY_W-1:0];
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void expect_word(logic [BYTE_W-1:0] d, logic [IDX_W-1:0] i, logic done,
                              logic drop, logic [CNT_OUT_W-1:0] c);
      strip_word_t w;
      w.data  = d;
      w.idx   = i;
      w.done  = done;
      w.drop  = drop;
      w.count = c;
      expected_words.push_back(w);
    endfunction

    // The first attached entry matching port and VLAN id decides the frame.
    function void classify(logic [BYTE_W-1:0] low, logic [PORT_W-1:0] port);
      logic [VID_W-1:0] vid;
      bit               found;
      vid     = {tag_hi[TAG_HI_W-1:0], low};
      verdict = VERD_DROP;
      matched = '0;
      found   = 1'b0;
      for (int i = 0; i < DEF_NUM_ENTRIES; i++) begin
        if (!found && entries[i][ENT_ATT] &&
            entries[i][ENT_PORT_LSB +: PORT_W] == port &&
            entries[i][VID_W-1:0] == vid) begin
          found   = 1'b1;
          matched = IDX_W'(i);
          verdict = entries[i][ENT_UP] ? VERD_ACCEPT : VERD_DROP;
        end
      end
    endfunction

    // Works out the words caused by one accepted input word.
    function void note_input(logic [BYTE_W-1:0] b, logic [PORT_W-1:0] port, logic eof);
      logic [IDX_W-1:0]     m;
      logic [CNT_OUT_W-1:0] c;
      int                   before_n;
      m        = matched;
      before_n = expected_words.size();
      if (pos < POS_TAG_HI) begin
        hdr[pos[HDR_AW-1:0]] = b;
      end
      if (pos == POS_TAG_HI) begin
        tag_hi = b;
      end else if (pos == POS_CLASSIFY) begin
        classify(b, port);
      end else if (pos == POS_ETYPE) begin
        hdr[ETYPE_SLOT] = b;
      end else if (pos == POS_EMIT && verdict == VERD_ACCEPT) begin
        counters[m] = counters[m] + 1'b1;
        c = counters[m][CNT_OUT_W-1:0];
        for (int i = 0; i < HDR_BYTES; i++) begin
          expect_word(hdr[i], m, 1'b0, 1'b0, c);
        end
        expect_word(b, m, 1'b0, 1'b0, c);
      end else if (pos > POS_EMIT && verdict == VERD_ACCEPT) begin
        expect_word(b, m, 1'b0, 1'b0, counters[m][CNT_OUT_W-1:0]);
      end
      if (pos < POS_SAT) begin
        pos = pos + 1'b1;
      end
      // The end of a frame either closes the forwarded words or gives one drop word.
      if (eof) begin
        if (expected_words.size() > before_n) begin
          expected_words[expected_words.size()-1].done = 1'b1;
        end else begin
          expect_word('0, '0, 1'b1, 1'b1, '0);
        end
        pos     = '0;
        verdict = VERD_UNDEC;
        matched = '0;
        tag_hi  = '0;
      end
    endfunction

    // Compares one popped word with the oldest expectation.
    function void check_output(strip_word_t got);
      strip_word_t want;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected word: byte %h idx %0d done %b drop %b count %h",
                   got.data, got.idx, got.done, got.drop, got.count);
        end
      end else begin
        want = expected_words.pop_front();
        if (got.data !== want.data || got.idx !== want.idx || got.done !== want.done ||
            got.drop !== want.drop || got.count !== want.count) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch: expected byte %h idx %0d done %b drop %b count %h",
                     want.data, want.idx, want.done, want.drop, want.count);
            $display("          actual   byte %h idx %0d done %b drop %b count %h",
                     got.data, got.idx, got.done, got.drop, got.count);
          end
        end
      end
    endfunction
  endclass

  strip_scoreboard sb;
  strip_word_t     observed_word;
  int              cycles;
  int              words_sent;
  int              hold_asked;
  bit              send_calm;
  bit              recv_calm;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, a few long; none at all in calm stretches.
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one word and waits until the block takes it.
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic [PORT_W-1:0] p,
                           input logic e);
    int gap;
    gap = idle_len(send_calm);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push            <= 1'b1;
    in_frame_byte   <= b;
    in_arrival_port <= p;
    in_end_of_frame <= e;
    do @(posedge clk); while (full);
    sb.note_input(b, p, e);
    words_sent++;
  endtask

  // Sends one tagged frame; only the port given with the low VID byte should matter.
  task automatic send_frame(input int len, input logic [PORT_W-1:0] port,
                            input logic [VID_W-1:0] vid);
    logic [BYTE_W-1:0] b;
    logic [PORT_W-1:0] p;
    for (int k = 0; k < len; k++) begin
      b = BYTE_W'($urandom);
      p = ($urandom_range(0, 3) == 0) ? PORT_W'($urandom) : port;
      case (k)
        12: if ($urandom_range(0, 3) != 0) b = TPID[15:8];
        13: if ($urandom_range(0, 3) != 0) b = TPID[7:0];
        14: b[TAG_HI_W-1:0] = vid[VID_W-1:BYTE_W];
        15: begin
          b = vid[BYTE_W-1:0];
          p = port;
        end
        default: ;
      endcase
      send_word(b, p, k == len - 1);
    end
  endtask

  // Writes one entry register through a setup and an access cycle.
  task automatic write_entry(input entry_reg_t r, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * r);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_entry(r, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stops offering and waits until every expected word has come out.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random entries with few ports and VLAN ids, so that entries often overlap.
  task automatic program_random();
    logic [APB_DW-1:0] w;
    logic [APB_DW-1:0] prev;
    prev = '0;
    for (int i = 0; i < CFG_REGS; i++) begin
      w = $urandom;
      w[ENT_ATT] = ($urandom_range(0, 9) < 8);
      w[ENT_UP]  = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 1) == 1) begin
        w[ENT_PORT_LSB +: PORT_W] = PORT_W'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 3) == 0) begin
        w[ENT_PORT_LSB +: PORT_W] = prev[ENT_PORT_LSB +: PORT_W];
        w[VID_W-1:0]              = prev[VID_W-1:0];
      end else if ($urandom_range(0, 1) == 1) begin
        w[VID_W-1:0] = VID_W'($urandom_range(0, 3));
      end
      write_entry(entry_reg_t'(i), w);
      prev = w;
    end
  endtask

  // Mostly frames aimed at a configured entry, some at nothing, some short or long.
  task automatic run_frames(input int n_words);
    int                start;
    int                r;
    int                i;
    int                len;
    logic [PORT_W-1:0] port;
    logic [VID_W-1:0]  vid;
    start = words_sent;
    while (words_sent - start < n_words) begin
      r    = $urandom_range(0, 99);
      i    = $urandom_range(0, CFG_REGS - 1);
      port = sb.entries[i][ENT_PORT_LSB +: PORT_W];
      vid  = sb.entries[i][VID_W-1:0];
      if (r < 12) len = $urandom_range(1, 17);
      else if (r < 22) len = $urandom_range(29, 64);
      else len = $urandom_range(18, 28);
      if (r >= 82) begin
        port = PORT_W'($urandom);
        vid  = VID_W'($urandom);
      end
      send_frame(len, port, vid);
    end
  endtask

  // Receiver: random pop gaps, calm stretches and one long hold-off on request.
  initial begin
    int hold_left;
    int idle_left;
    int hold_served;
    hold_left   = 0;
    idle_left   = 0;
    hold_served = 0;
    pop         = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (idle_left > 0) begin
        pop <= 1'b0;
        idle_left--;
      end else begin
        pop <= 1'b1;
        idle_left = idle_len(recv_calm);
      end
    end
  end

  // Every popped word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      observed_word.data  = out_byte;
      observed_word.idx   = out_vlan_index;
      observed_word.done  = out_frame_done;
      observed_word.drop  = out_dropped;
      observed_word.count = out_packet_count;
      sb.check_output(observed_word);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    cycles          = 0;
    words_sent      = 0;
    hold_asked      = 0;
    send_calm       = 1'b0;
    recv_calm       = 1'b0;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_frame_byte   = '0;
    in_arrival_port = '0;
    in_end_of_frame = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();

    // Directed: top port and VLAN id accepted, short frames dropped, one entry down.
    write_entry(REG_ENTRY_ZERO, 32'h0003_FFFF);
    write_entry(REG_ENTRY_ONE, 32'h0003_0000);
    write_entry(REG_ENTRY_TWO, 32'h0002_3123);
    write_entry(REG_ENTRY_THREE, 32'hFFFC_0000);
    send_frame(1, 4'h0, 12'h000);
    send_frame(18, 4'hF, 12'hFFF);
    send_frame(3, 4'hF, 12'hFFF);
    drain();

    // Every entry at its all-ones extreme: the first one always decides.
    for (int i = 0; i < CFG_REGS; i++) begin
      write_entry(entry_reg_t'(i), {14'($urandom), 18'h3FFFF});
    end
    run_frames(50);
    drain();

    // Every entry cleared: nothing is attached, so every frame is dropped.
    for (int i = 0; i < CFG_REGS; i++) begin
      write_entry(entry_reg_t'(i), {14'($urandom), 18'h00000});
    end
    run_frames(40);
    drain();

    // Random settings; one phase with a long receiver hold-off, one without gaps.
    for (int ph = 0; ph < 4; ph++) begin
      program_random();
      send_calm = (ph == 2);
      recv_calm = (ph == 2);
      if (ph == 1) hold_asked++;
      run_frames(80);
      drain();
    end
    send_calm = 1'b0;
    recv_calm = 1'b0;

    if (sb.failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/vics_pkg.sv
rtl/vics_fifo.sv
rtl/vics_front.sv
rtl/vics_back.sv
rtl/vlan_ingress_classify_strip_top.sv
rtl/vics_checker.sv
tb/sv/tb.sv
